FILE: rtl/pfrm_pkg.sv
// Shared types, constants and sequencer states of the per-flow rate meter.
// No dependencies; every other file but pfrm_ram imports this package.
`default_nettype none
package pfrm_pkg;

  localparam int MAX_FLOWS_DEF    = 64;
  localparam int WINDOW_DEPTH_DEF = 4;

  localparam int PORT_W      = 16;
  localparam int LEN_W       = 16;
  localparam int ETYPE_W     = 16;
  localparam int VER_W       = 4;
  localparam int KEY_W       = 2 * PORT_W;
  localparam int FLOW_ID_W   = 7;
  localparam int FILL_W      = 3;
  localparam int RATE_W      = 32;
  localparam int BYTE_SUM_W  = 32;
  localparam int IVL_W       = 16;
  localparam int OVH_W       = 8;
  localparam int CFG_DATA_W  = 16;

  localparam int RATE_SHIFT  = 19;
  localparam int NUM_W       = BYTE_SUM_W + RATE_SHIFT;
  localparam int DEN_W       = 26;
  localparam int DCNT_W      = $clog2(NUM_W + 1);
  localparam int MS_SCALE    = 1000;

  localparam logic [IVL_W-1:0]   IVL_RESET      = IVL_W'(1000);
  localparam logic [OVH_W-1:0]   OVH_RESET      = OVH_W'(28);
  localparam logic [LEN_W-1:0]   ETH_HDR_BYTES  = LEN_W'(14);
  localparam logic [LEN_W-1:0]   MIN_WIRE_BYTES = LEN_W'(34);
  localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = ETYPE_W'(16'h0800);
  localparam logic [VER_W-1:0]   IP_VERSION_V4  = VER_W'(4);

  typedef enum logic {
    ACT_PACKET = 1'b0,
    ACT_TICK   = 1'b1
  } action_t;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_EMPTY  = 1'b1
  } kind_t;

  typedef enum logic [0:0] {
    CFG_INTERVAL_MS     = 1'b0,
    CFG_HEADER_OVERHEAD = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    action_t              action;
    logic [LEN_W-1:0]     captured_length;
    logic [LEN_W-1:0]     wire_length;
    logic [ETYPE_W-1:0]   ethertype;
    logic [VER_W-1:0]     ip_version;
    logic [LEN_W-1:0]     ip_total_length;
    logic [PORT_W-1:0]    sport;
    logic [PORT_W-1:0]    dport;
  } in_item_t;

  typedef struct packed {
    kind_t                kind;
    logic [FLOW_ID_W-1:0] flow_id;
    logic [RATE_W-1:0]    smoothed_rate;
    logic [FILL_W-1:0]    window_fill;
    logic                 table_overflow;
    logic                 last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_KEY_RD,
    S_KEY_CMP,
    S_NEW,
    S_SUM_RD,
    S_SUM_UPD,
    S_T_RD,
    S_T_LOAD,
    S_DIV,
    S_W_RD,
    S_W_TAKE,
    S_W_PUSH,
    S_SORT,
    S_PICK,
    S_PAIR,
    S_WB,
    S_EMIT,
    S_EMPTY
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/pfrm_in_if.sv
// Input channel of the rate meter: valid/ready handshake with a packet or tick item.
// Depends on pfrm_pkg for the payload type.
`default_nettype none
interface pfrm_in_if;
  import pfrm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/pfrm_out_if.sv
// Result channel of the rate meter: valid/ready handshake with one flow report.
// Depends on pfrm_pkg for the payload type.
`default_nettype none
interface pfrm_out_if;
  import pfrm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/pfrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pfrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/per_flow_rate_meter_core.sv
// Per-flow rate meter: flow table, byte sums, per-flow rate windows, smoothed reports.
// Depends on pfrm_pkg, pfrm_in_if, pfrm_out_if and pfrm_ram.
//
// Usage: items arrive on in_chan (valid/ready); action selects packet or tick.
// A packet that passes the IPv4 filter is matched by port pair against the flow
// table, one key RAM read per entry in S_KEY_RD and compare in S_KEY_CMP, then
// its byte count is added to the flow sum; other packets are dropped. A tick
// walks the flows in id order; per flow a shared restoring divider forms the
// rate, the window is loaded from RAM entry by entry, sorted by WINDOW_DEPTH
// odd-even passes, scanned pair by pair, and the chosen span is averaged by the
// same divider (skipped when the window holds one entry or all equal values);
// the window is then written back.
// One report per flow leaves on out_chan through an output register; the last
// carries last=1. A tick with no flows gives one empty report.
// in_chan.ready is high only when the sequencer is idle. A stalled out_chan
// holds the sequencer at the next report. Reset (rst_n low, synchronous) clears
// the flow count, the overflow flag and the output, and loads the register
// defaults; RAM contents are written before they are read and need no clearing.
// Write configuration on cfg_we only while the block is idle.
`default_nettype none
module per_flow_rate_meter_core #(
  parameter int MAX_FLOWS    = pfrm_pkg::MAX_FLOWS_DEF,
  parameter int WINDOW_DEPTH = pfrm_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pfrm_in_if.sink                           in_chan,
  pfrm_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  pfrm_pkg::cfg_idx_t                cfg_idx,
  input  logic [pfrm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pfrm_pkg::*;

  localparam int FW     = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int CW     = $clog2(MAX_FLOWS + 1);
  localparam int KW     = $clog2(WINDOW_DEPTH);
  localparam int NW     = $clog2(WINDOW_DEPTH + 1);
  localparam int SW     = RATE_W + NW;
  localparam int N2W    = 2 * NW;
  localparam int SRAM_W = BYTE_SUM_W + NW;
  localparam int FDEPTH = 2 ** FW;
  localparam int WDEPTH = 2 ** (FW + KW);

  state_t state_r, state_nxt;

  logic [IVL_W-1:0]      ivl_r;
  logic [OVH_W-1:0]      ovh_r;
  logic [CW-1:0]         flow_cnt_r;
  logic                  ovf_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic [KEY_W-1:0]      key_r;
  logic [LEN_W-1:0]      add_r;
  logic [FW-1:0]         idx_r;
  logic [NW-1:0]         c0_r, n_r, k_r, i_r, j_r, bcnt_r;
  logic [NUM_W-1:0]      num_r;
  logic [DEN_W-1:0]      den_r, rem_r;
  logic [RATE_W-1:0]     quo_r;
  logic                  qovf_r;
  logic [DCNT_W-1:0]     dcnt_r;
  logic                  mean_mode_r;
  logic [RATE_W-1:0]     rate_r, smooth_r, min_r, max_r, bd_r;
  logic [RATE_W-1:0]     win_r [WINDOW_DEPTH];
  logic [RATE_W-1:0]     s_r   [WINDOW_DEPTH];
  logic [RATE_W-1:0]     u_r   [WINDOW_DEPTH];
  logic [SW-1:0]         acc_r, bsum_r;
  logic                  have_r;
  logic [N2W-1:0]        bn2_r;

  // RAM ports
  logic                  key_we;
  logic [FW-1:0]         key_waddr, key_raddr;
  logic [KEY_W-1:0]      key_rdata;
  logic                  sum_we;
  logic [FW-1:0]         sum_waddr, sum_raddr;
  logic [SRAM_W-1:0]     sum_wdata, sum_rdata;
  logic                  win_we;
  logic [FW+KW-1:0]      win_waddr, win_raddr;
  logic [RATE_W-1:0]     win_rdata;

  // control terms
  logic                  in_fire, pass, slot_free, last_idx, key_hit, full, trivial;
  logic                  adv_j, adv_i, take, out_load, emit_last, wb_write;
  logic [LEN_W-1:0]      add_new;
  logic [IVL_W-1:0]      ivl_eff;
  logic [BYTE_SUM_W:0]   sum_ext;
  logic [BYTE_SUM_W-1:0] sum_sat;
  logic [DEN_W:0]        div_t;
  logic                  div_ge;
  logic [RATE_W-1:0]     win_in, push_min, push_max, rng, d;
  logic [RATE_W-1:0]     win_sh [WINDOW_DEPTH];
  logic [RATE_W-1:0]     s_srt  [WINDOW_DEPTH];
  logic [NW-1:0]         cnt, n_new;
  logic [N2W-1:0]        n2;
  logic [RATE_W+NW-1:0]  dn;
  logic [RATE_W+N2W-1:0] lhs, rhs;
  logic [SW-1:0]         acc_cur, bsum_sel;
  logic [NW-1:0]         bcnt_sel;

  pfrm_ram #(.WIDTH(KEY_W), .DEPTH(FDEPTH)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_r),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  pfrm_ram #(.WIDTH(SRAM_W), .DEPTH(FDEPTH)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rdata)
  );

  pfrm_ram #(.WIDTH(RATE_W), .DEPTH(WDEPTH)) u_win_ram (
    .clk(clk), .we(win_we), .waddr(win_waddr), .wdata(win_r[0]),
    .raddr(win_raddr), .rdata(win_rdata)
  );

  always_comb begin
    in_fire   = in_chan.valid && in_chan.ready;
    pass      = (in_chan.data.captured_length >= ETH_HDR_BYTES) &&
                (in_chan.data.ethertype == ETHERTYPE_IPV4) &&
                (in_chan.data.wire_length >= MIN_WIRE_BYTES) &&
                (in_chan.data.ip_version == IP_VERSION_V4);
    add_new   = (in_chan.data.ip_total_length > LEN_W'(ovh_r)) ?
                in_chan.data.ip_total_length - LEN_W'(ovh_r) : '0;
    slot_free = !out_valid_r || out_chan.ready;
    last_idx  = (CW'(idx_r) + CW'(1)) >= flow_cnt_r;
    key_hit   = key_rdata == key_r;
    full      = flow_cnt_r >= CW'(MAX_FLOWS);
    ivl_eff   = (ivl_r == '0) ? IVL_W'(1) : ivl_r;
    sum_ext   = {1'b0, sum_rdata[BYTE_SUM_W-1:0]} + (BYTE_SUM_W+1)'(add_r);
    sum_sat   = sum_ext[BYTE_SUM_W] ? '1 : sum_ext[BYTE_SUM_W-1:0];
    div_t     = {rem_r, num_r[NUM_W-1]};
    div_ge    = div_t >= {1'b0, den_r};
    take      = (NW'(1) + k_r) >= c0_r;
    n_new     = (c0_r >= NW'(WINDOW_DEPTH)) ? NW'(WINDOW_DEPTH) : c0_r + NW'(1);
    trivial   = (n_r == NW'(1)) || (max_r == min_r);
    wb_write  = k_r >= (NW'(WINDOW_DEPTH) - n_r);
  end

  // window line shift, sort pass
  always_comb begin
    win_in = (state_r == S_W_PUSH) ? rate_r :
             (state_r == S_W_TAKE) ? win_rdata : '1;
    for (int e = 0; e < WINDOW_DEPTH - 1; e++) begin
      win_sh[e] = win_r[e+1];
    end
    win_sh[WINDOW_DEPTH-1] = win_in;
    push_min = (win_in < min_r) ? win_in : min_r;
    push_max = (win_in > max_r) ? win_in : max_r;
    for (int e = 0; e < WINDOW_DEPTH; e++) begin
      s_srt[e] = s_r[e];
    end
    for (int e = 0; e < WINDOW_DEPTH - 1; e++) begin
      if ((e[0] == k_r[0]) && (s_r[e] > s_r[e+1])) begin
        s_srt[e]   = s_r[e+1];
        s_srt[e+1] = s_r[e];
      end
    end
  end

  // densest-span pair test
  always_comb begin
    rng      = max_r - min_r;
    d        = u_r[0] - s_r[0];
    cnt      = j_r - i_r + NW'(1);
    n2       = N2W'(cnt) * N2W'(cnt);
    dn       = (RATE_W+NW)'(d) * (RATE_W+NW)'(n_r - NW'(1));
    lhs      = (RATE_W+N2W)'(n2) * (RATE_W+N2W)'(bd_r);
    rhs      = (RATE_W+N2W)'(bn2_r) * (RATE_W+N2W)'(d);
    acc_cur  = acc_r + SW'(u_r[0]);
    adv_j    = ({1'b0, j_r} + (NW+1)'(1)) < {1'b0, n_r};
    adv_i    = ({1'b0, i_r} + (NW+1)'(2)) < {1'b0, n_r};
    bsum_sel = bsum_r;
    bcnt_sel = bcnt_r;
    if ((dn >= (RATE_W+NW)'(rng)) && (!have_r || (lhs > rhs))) begin
      bsum_sel = acc_cur;
      bcnt_sel = cnt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_chan.data.action == ACT_TICK) begin
            state_nxt = (flow_cnt_r == '0) ? S_EMPTY : S_T_RD;
          end else if (pass) begin
            state_nxt = (flow_cnt_r == '0) ? S_NEW : S_KEY_RD;
          end
        end
      end
      S_KEY_RD:  state_nxt = S_KEY_CMP;
      S_KEY_CMP: state_nxt = key_hit ? S_SUM_RD : (last_idx ? S_NEW : S_KEY_RD);
      S_NEW:     state_nxt = S_IDLE;
      S_SUM_RD:  state_nxt = S_SUM_UPD;
      S_SUM_UPD: state_nxt = S_IDLE;
      S_T_RD:    state_nxt = S_T_LOAD;
      S_T_LOAD:  state_nxt = S_DIV;
      S_DIV: begin
        if (dcnt_r == '0) begin
          if (mean_mode_r) begin
            state_nxt = S_WB;
          end else begin
            state_nxt = (c0_r == '0) ? S_W_PUSH : S_W_RD;
          end
        end
      end
      S_W_RD:    state_nxt = S_W_TAKE;
      S_W_TAKE:  state_nxt = take ? S_W_PUSH : S_W_RD;
      S_W_PUSH:  state_nxt = S_SORT;
      S_SORT:    state_nxt = (k_r == NW'(WINDOW_DEPTH - 1)) ? S_PICK : S_SORT;
      S_PICK:    state_nxt = trivial ? S_WB : S_PAIR;
      S_PAIR:    state_nxt = (adv_j || adv_i) ? S_PAIR : S_DIV;
      S_WB:      state_nxt = (k_r == NW'(WINDOW_DEPTH - 1)) ? S_EMIT : S_WB;
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = last_idx ? S_IDLE : S_T_RD;
        end
      end
      S_EMPTY:   state_nxt = slot_free ? S_IDLE : S_EMPTY;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = state_r == S_IDLE;
    out_load      = ((state_r == S_EMIT) || (state_r == S_EMPTY)) && slot_free;
    emit_last     = (state_r == S_EMIT) && slot_free && last_idx;
    key_we        = (state_r == S_NEW) && !full;
    key_waddr     = flow_cnt_r[FW-1:0];
    key_raddr     = idx_r;
    sum_we        = 1'b0;
    sum_waddr     = idx_r;
    sum_wdata     = {sum_rdata[SRAM_W-1 -: NW], sum_sat};
    sum_raddr     = idx_r;
    case (state_r)
      S_NEW: begin
        sum_we    = !full;
        sum_waddr = flow_cnt_r[FW-1:0];
        sum_wdata = {NW'(0), BYTE_SUM_W'(add_r)};
      end
      S_SUM_UPD: sum_we = 1'b1;
      S_WB: begin
        sum_we    = k_r == '0;
        sum_wdata = {n_r, BYTE_SUM_W'(0)};
      end
      default: sum_we = 1'b0;
    endcase
    win_we    = (state_r == S_WB) && wb_write;
    win_waddr = {idx_r, KW'(k_r + n_r - NW'(WINDOW_DEPTH))};
    win_raddr = {idx_r, k_r[KW-1:0]};
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flow_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      ivl_r       <= IVL_RESET;
      ovh_r       <= OVH_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_INTERVAL_MS:     ivl_r <= cfg_wdata[IVL_W-1:0];
          CFG_HEADER_OVERHEAD: ovh_r <= cfg_wdata[OVH_W-1:0];
          default:             ivl_r <= ivl_r;
        endcase
      end
      if (state_r == S_NEW) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          flow_cnt_r <= flow_cnt_r + CW'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_r <= {in_chan.data.sport, in_chan.data.dport};
          add_r <= add_new;
          idx_r <= '0;
        end
      end
      S_KEY_CMP: begin
        if (!key_hit && !last_idx) begin
          idx_r <= idx_r + FW'(1);
        end
      end
      S_T_LOAD: begin
        num_r       <= {sum_rdata[BYTE_SUM_W-1:0], RATE_SHIFT'(0)};
        den_r       <= DEN_W'(ivl_eff * MS_SCALE);
        rem_r       <= '0;
        quo_r       <= '0;
        qovf_r      <= 1'b0;
        dcnt_r      <= DCNT_W'(NUM_W);
        mean_mode_r <= 1'b0;
        c0_r        <= sum_rdata[SRAM_W-1 -: NW];
        k_r         <= '0;
        min_r       <= '1;
        max_r       <= '0;
        for (int e = 0; e < WINDOW_DEPTH; e++) begin
          win_r[e] <= '1;
        end
      end
      S_DIV: begin
        if (dcnt_r != '0) begin
          rem_r  <= div_ge ? DEN_W'(div_t - {1'b0, den_r}) : div_t[DEN_W-1:0];
          num_r  <= num_r << 1;
          quo_r  <= {quo_r[RATE_W-2:0], div_ge};
          qovf_r <= qovf_r | quo_r[RATE_W-1];
          dcnt_r <= dcnt_r - DCNT_W'(1);
        end else if (mean_mode_r) begin
          smooth_r <= quo_r;
        end else begin
          rate_r <= qovf_r ? '1 : quo_r;
        end
      end
      S_W_TAKE: begin
        win_r <= win_sh;
        if ((c0_r < NW'(WINDOW_DEPTH)) || (k_r != '0)) begin
          min_r <= push_min;
          max_r <= push_max;
        end
        k_r   <= k_r + NW'(1);
      end
      S_W_PUSH: begin
        win_r <= win_sh;
        s_r   <= win_sh;
        min_r <= push_min;
        max_r <= push_max;
        n_r   <= n_new;
        k_r   <= '0;
      end
      S_SORT: begin
        s_r <= s_srt;
        k_r <= k_r + NW'(1);
      end
      S_PICK: begin
        k_r <= '0;
        if (trivial) begin
          smooth_r <= min_r;
        end else begin
          for (int e = 0; e < WINDOW_DEPTH - 1; e++) begin
            u_r[e] <= s_r[e+1];
          end
          u_r[WINDOW_DEPTH-1] <= '1;
          i_r    <= '0;
          j_r    <= NW'(1);
          acc_r  <= SW'(s_r[0]);
          have_r <= 1'b0;
          bn2_r  <= '0;
          bd_r   <= RATE_W'(1);
        end
      end
      S_PAIR: begin
        if ((dn >= (RATE_W+NW)'(rng)) && (!have_r || (lhs > rhs))) begin
          have_r <= 1'b1;
          bn2_r  <= n2;
          bd_r   <= d;
        end
        bsum_r <= bsum_sel;
        bcnt_r <= bcnt_sel;
        if (adv_j) begin
          j_r   <= j_r + NW'(1);
          acc_r <= acc_cur;
          for (int e = 0; e < WINDOW_DEPTH - 1; e++) begin
            u_r[e] <= u_r[e+1];
          end
          u_r[WINDOW_DEPTH-1] <= '1;
        end else if (adv_i) begin
          i_r   <= i_r + NW'(1);
          j_r   <= i_r + NW'(2);
          acc_r <= SW'(s_r[1]);
          for (int e = 0; e < WINDOW_DEPTH - 1; e++) begin
            s_r[e] <= s_r[e+1];
          end
          s_r[WINDOW_DEPTH-1] <= '1;
          for (int e = 0; e < WINDOW_DEPTH - 2; e++) begin
            u_r[e] <= s_r[e+2];
          end
          for (int e = WINDOW_DEPTH - 2; e < WINDOW_DEPTH; e++) begin
            u_r[e] <= '1;
          end
        end else begin
          num_r       <= NUM_W'(bsum_sel);
          den_r       <= DEN_W'(bcnt_sel);
          rem_r       <= '0;
          quo_r       <= '0;
          qovf_r      <= 1'b0;
          dcnt_r      <= DCNT_W'(NUM_W);
          mean_mode_r <= 1'b1;
        end
      end
      S_WB: begin
        win_r <= win_sh;
        k_r   <= k_r + NW'(1);
      end
      S_EMIT: begin
        if (slot_free && !last_idx) begin
          idx_r <= idx_r + FW'(1);
        end
      end
      default: begin
        rate_r <= rate_r;
      end
    endcase
    if (out_load) begin
      if (state_r == S_EMPTY) begin
        out_data_r.kind          <= KIND_EMPTY;
        out_data_r.flow_id       <= '0;
        out_data_r.smoothed_rate <= '0;
        out_data_r.window_fill   <= '0;
        out_data_r.last          <= 1'b1;
      end else begin
        out_data_r.kind          <= KIND_REPORT;
        out_data_r.flow_id       <= FLOW_ID_W'(idx_r) + FLOW_ID_W'(1);
        out_data_r.smoothed_rate <= smooth_r;
        out_data_r.window_fill   <= FILL_W'(n_r);
        out_data_r.last          <= last_idx;
      end
      out_data_r.table_overflow <= ovf_r;
    end
  end

  a_flow_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    flow_cnt_r <= CW'(MAX_FLOWS))
    else $error("flow count above table size");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared");

  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && dcnt_r != '0) |-> den_r != '0)
    else $error("divide by zero");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_last |=> state_r == S_IDLE)
    else $error("sequencer busy after last report");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for per_flow_rate_meter_core: packet filtering, flow table,
// per-flow rate windows and the smoothed tick reports, with random idling on both sides.
// Depends on pfrm_pkg, pfrm_in_if, pfrm_out_if and the RTL of the core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pfrm_pkg::*;

  localparam int NFLOW = MAX_FLOWS_DEF;
  localparam int WDEP  = WINDOW_DEPTH_DEF;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pfrm_in_if  in_chan ();
  pfrm_out_if out_chan ();

  per_flow_rate_meter_core u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // meter state mirror
  logic [15:0] ivl_ms;
  logic [7:0]  ovh_bytes;
  logic [31:0] key_tab [NFLOW];
  logic [31:0] sum_tab [NFLOW];
  logic [31:0] win_tab [NFLOW][WDEP];
  int          fill_tab [NFLOW];
  int          n_flows;
  logic        ovf_flag;

  out_item_t report_q [$];
  int errors, n_pkt_counted, n_ticks, n_reports;
  bit burst_mode;
  int out_stall;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] smooth_rate(logic [31:0] w [WDEP], int n);
    logic [31:0] s [WDEP];
    logic [31:0] v;
    longint unsigned rng, d, n2, bn2, bd, tot;
    int k, bl, br;
    bit have;
    for (int i = 0; i < n; i++) begin
      v = w[i];
      k = i;
      while (k > 0 && s[k-1] > v) begin
        s[k] = s[k-1];
        k--;
      end
      s[k] = v;
    end
    if (n == 1) return s[0];
    rng = longint'(s[n-1]) - longint'(s[0]);
    if (rng == 0) return s[0];
    have = 0; bn2 = 0; bd = 1; bl = 0; br = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        d = longint'(s[j]) - longint'(s[i]);
        n2 = longint'((j - i + 1) * (j - i + 1));
        if (d * longint'(n - 1) >= rng) begin
          if (!have || n2 * bd > bn2 * d) begin
            have = 1; bn2 = n2; bd = d; bl = i; br = j;
          end
        end
      end
    end
    tot = 0;
    for (int i = bl; i <= br; i++) tot += s[i];
    return 32'(tot / longint'(br - bl + 1));
  endfunction

  task automatic meter_accept(in_item_t it);
    logic [31:0] key;
    logic [32:0] acc;
    logic [15:0] add;
    longint unsigned dv, r;
    logic [31:0] rate;
    int id;
    out_item_t o;
    if (it.action == ACT_PACKET) begin
      if (it.captured_length < 14 || it.ethertype != 16'h0800 ||
          it.wire_length < 34 || it.ip_version != 4) return;
      key = {it.sport, it.dport};
      id = n_flows;
      for (int f = 0; f < n_flows; f++) if (key_tab[f] == key) begin
        id = f;
        break;
      end
      if (id == n_flows) begin
        if (n_flows >= NFLOW) begin
          ovf_flag = 1'b1;
          return;
        end
        key_tab[id] = key; sum_tab[id] = 0; fill_tab[id] = 0;
        n_flows++;
      end
      add = (it.ip_total_length > ovh_bytes) ? it.ip_total_length - ovh_bytes : 16'd0;
      acc = sum_tab[id] + add;
      sum_tab[id] = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
      n_pkt_counted++;
    end else begin
      n_ticks++;
      if (n_flows == 0) begin
        o.kind = KIND_EMPTY; o.flow_id = '0; o.smoothed_rate = '0;
        o.window_fill = '0; o.table_overflow = ovf_flag; o.last = 1'b1;
        report_q.insert(report_q.size(), o);
        return;
      end
      dv = longint'((ivl_ms == 0) ? 16'd1 : ivl_ms) * 1000;
      for (int f = 0; f < n_flows; f++) begin
        r = (longint'(sum_tab[f]) << 19) / dv;
        rate = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
        if (fill_tab[f] >= WDEP) begin
          for (int k = 0; k < WDEP - 1; k++) win_tab[f][k] = win_tab[f][k+1];
          win_tab[f][WDEP-1] = rate;
        end else begin
          win_tab[f][fill_tab[f]] = rate;
          fill_tab[f]++;
        end
        o.kind = KIND_REPORT;
        o.flow_id = FLOW_ID_W'(f + 1);
        o.smoothed_rate = smooth_rate(win_tab[f], fill_tab[f]);
        o.window_fill = FILL_W'(fill_tab[f]);
        o.table_overflow = ovf_flag;
        o.last = (f + 1 == n_flows);
        report_q.insert(report_q.size(), o);
        sum_tab[f] = 0;
      end
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // result channel: random stall per beat, burst mode keeps ready high
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        n_reports++;
        if (report_q.size() == 0) begin
          $display("[%0t] unexpected report flow_id %0d", $time, out_chan.data.flow_id);
          errors++;
        end else begin
          automatic out_item_t w = report_q.pop_front();
          automatic out_item_t g = out_chan.data;
          if (g.kind != w.kind) report_mismatch("kind", g.kind, w.kind);
          if (g.flow_id != w.flow_id) report_mismatch("flow_id", g.flow_id, w.flow_id);
          if (g.smoothed_rate != w.smoothed_rate)
            report_mismatch("smoothed_rate", g.smoothed_rate, w.smoothed_rate);
          if (g.window_fill != w.window_fill)
            report_mismatch("window_fill", g.window_fill, w.window_fill);
          if (g.table_overflow != w.table_overflow)
            report_mismatch("table_overflow", g.table_overflow, w.table_overflow);
          if (g.last != w.last) report_mismatch("last", g.last, w.last);
        end
        out_stall = burst_mode ? 0 : $urandom_range(0, 9);
      end
      if (out_stall > 0) begin
        out_chan.ready <= 1'b0;
        out_stall--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(in_item_t it);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= it;
    do @(posedge clk); while (!in_chan.ready);
    meter_accept(it);
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    settle();
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_INTERVAL_MS) ivl_ms = val;
    else ovh_bytes = val[7:0];
  endtask

  function automatic in_item_t good_pkt(logic [15:0] sp, logic [15:0] dp, logic [15:0] tl);
    in_item_t it;
    it.action = ACT_PACKET;
    it.captured_length = 16'($urandom_range(14, 65535));
    it.wire_length = 16'($urandom_range(34, 65535));
    it.ethertype = ETHERTYPE_IPV4;
    it.ip_version = IP_VERSION_V4;
    it.ip_total_length = tl;
    it.sport = sp;
    it.dport = dp;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it = rand_item();
    it.action = ACT_TICK;
    return it;
  endfunction

  task automatic test_empty_tick();
    send_beat(tick_item());
  endtask

  task automatic test_filter();
    in_item_t it;
    it = good_pkt(16'h0001, 16'h0002, 16'd1000); it.captured_length = 16'd13; send_beat(it);
    it = good_pkt(16'h0001, 16'h0002, 16'd1000); it.ethertype = 16'h86DD; send_beat(it);
    it = good_pkt(16'h0001, 16'h0002, 16'd1000); it.wire_length = 16'd33; send_beat(it);
    it = good_pkt(16'h0001, 16'h0002, 16'd1000); it.ip_version = 4'd6; send_beat(it);
    it = good_pkt(16'h0001, 16'h0002, 16'd1000);
    it.captured_length = 16'd14; it.wire_length = 16'd34; send_beat(it);
    it = good_pkt(16'hFFFF, 16'hFFFF, 16'hFFFF);
    it.captured_length = 16'hFFFF; it.wire_length = 16'hFFFF; send_beat(it);
    send_beat(good_pkt(16'h0000, 16'h0000, 16'd0));
    send_beat(good_pkt(16'h0000, 16'h0000, 16'd28));
    send_beat(tick_item());
  endtask

  task automatic test_windows();
    logic [15:0] lens [5] = '{16'd100, 16'd100, 16'd9000, 16'd300, 16'd65535};
    foreach (lens[i]) begin
      send_beat(good_pkt(16'h0001, 16'h0002, lens[i]));
      send_beat(good_pkt(16'hFFFF, 16'hFFFF, 16'd500));
      send_beat(tick_item());
    end
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_INTERVAL_MS, 16'd1);
    write_reg(CFG_HEADER_OVERHEAD, 16'd0);
    send_beat(good_pkt(16'h0001, 16'h0002, 16'hFFFF));
    send_beat(tick_item());
    write_reg(CFG_INTERVAL_MS, 16'd0);
    write_reg(CFG_HEADER_OVERHEAD, 16'd255);
    send_beat(good_pkt(16'h0001, 16'h0002, 16'd255));
    send_beat(good_pkt(16'hFFFF, 16'hFFFF, 16'd256));
    send_beat(tick_item());
    write_reg(CFG_INTERVAL_MS, 16'hFFFF);
    write_reg(CFG_HEADER_OVERHEAD, 16'd28);
    send_beat(good_pkt(16'h0000, 16'h0000, 16'hFFFF));
    send_beat(tick_item());
  endtask

  task automatic test_random(int count);
    logic [15:0] sp_pool [6];
    logic [15:0] dp_pool [6];
    in_item_t it;
    int k;
    foreach (sp_pool[i]) begin
      sp_pool[i] = 16'($urandom);
      dp_pool[i] = 16'($urandom);
    end
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        settle();
        write_reg(CFG_INTERVAL_MS, 16'($urandom_range(1, 20) * ($urandom_range(0, 1) ? 1 : 50)));
        write_reg(CFG_HEADER_OVERHEAD, 16'($urandom_range(0, 255)));
        burst_mode = (n % 120 == 60);
      end
      k = $urandom_range(0, 99);
      if (k < 15) begin
        it = tick_item();
      end else if (k < 85) begin
        it = good_pkt(sp_pool[k % 6], dp_pool[k % 6], 16'($urandom_range(0, 65535)));
        if ($urandom_range(0, 3) == 0) it.ip_total_length = 16'($urandom_range(0, 300));
      end else begin
        it = rand_item();
        it.action = ACT_PACKET;
        if ($urandom_range(0, 1)) begin
          it.sport = sp_pool[k % 6];
          it.dport = dp_pool[k % 6];
        end
      end
      send_beat(it);
    end
    burst_mode = 0;
  endtask

  task automatic test_table_full();
    write_reg(CFG_INTERVAL_MS, 16'd1000);
    for (int f = 0; f < NFLOW + 2; f++)
      send_beat(good_pkt(16'(16'h4000 + f), 16'($urandom), 16'($urandom_range(0, 65535))));
    for (int t = 0; t < 2; t++) begin
      send_beat(good_pkt(16'h0001, 16'h0002, 16'd1500));
      send_beat(tick_item());
    end
  endtask

  initial begin
    int wait_cycles;
    errors = 0; n_pkt_counted = 0; n_ticks = 0; n_reports = 0;
    burst_mode = 0;
    ivl_ms = IVL_RESET; ovh_bytes = OVH_RESET;
    n_flows = 0; ovf_flag = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_INTERVAL_MS;
    cfg_wdata <= '0;
    in_chan.valid <= 1'b0;
    in_chan.data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_tick();
    test_filter();
    test_windows();
    test_config_extremes();
    test_random(370);
    test_table_full();

    in_chan.valid <= 1'b0;
    wait_cycles = 0;
    while (report_q.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (300) @(posedge clk);

    $display("covered %0d counted packets, %0d ticks, %0d reports, %0d flows, overflow %0b",
             n_pkt_counted, n_ticks, n_reports, n_flows, ovf_flag);
    if (errors == 0 && report_q.size() == 0) begin
      $display("per_flow_rate_meter_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d reports outstanding", errors, report_q.size());
      $display("per_flow_rate_meter_core regression: fail");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("per_flow_rate_meter_core regression: fail");
    $finish;
  end

endmodule
